@@ src/slot_key_value_table_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the slot key-value table core.
// Both macros expect clk and rst_n in scope and are disabled during reset.
// ---------------------------------------------------------------------------
`ifndef SLOT_KEY_VALUE_TABLE_CORE_MACROS_SVH
`define SLOT_KEY_VALUE_TABLE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKVT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/skvt_pkg.sv @@
// ---------------------------------------------------------------------------
// skvt_pkg
// Shared widths, codes, word types and control structs of the slot
// key-value table.
// ---------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

    localparam int KEY_W     = 32;
    localparam int LEN_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int STAT_W    = 3;
    localparam int MODE_W    = 2;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BYTE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd3;

    localparam logic [STAT_W-1:0] ST_STORED    = 3'd0;
    localparam logic [STAT_W-1:0] ST_TOO_LONG  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_DELETED   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_CAP  = 1'b1;

    localparam logic [CFG_W-1:0] SLOT_COUNT_RST = 7'd64;
    localparam logic [CFG_W-1:0] VALUE_CAP_RST  = 7'd64;

    // All ones marks an empty slot and is never found.
    localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [KEY_W-1:0] key;
        logic [LEN_W-1:0]        val_len;
        logic [BYTE_W-1:0]       value_byte;
    } skvt_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [KEY_W-1:0] found_key;
        logic [LEN_W-1:0]        found_len;
        logic [BYTE_W-1:0]       found_byte;
        logic                    last;
    } skvt_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              in_take;
        logic              byte_store;
        logic              ins_commit;
        logic              ins_abort;
        logic              scan_start;
        logic              scan_issue;
        logic              hit_latch;
        logic              len_rd;
        logic              put_next;
        logic              del_write;
        logic              emit;
        logic [STAT_W-1:0] emit_status;
    } skvt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic              in_fire;
        logic [MODE_W-1:0] mode;
        logic              out_free;
        logic              too_long;
        logic              full;
        logic              key_empty;
        logic              scan_more;
        logic              rd_vld;
        logic              rd_hit;
        logic              put_last;
    } skvt_sts_t;

endpackage

`default_nettype wire

@@ src/skvt_chan_if.sv @@
// ---------------------------------------------------------------------------
// skvt_chan_if
// Valid/ready channel carrying one word of a packed payload type.
// ---------------------------------------------------------------------------
`default_nettype none

interface skvt_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ src/skvt_ctrl.sv @@
// ---------------------------------------------------------------------------
// skvt_ctrl
// Sequencing state machine: dispatch, slot search, delete and lookup run.
// ---------------------------------------------------------------------------
`default_nettype none

module skvt_ctrl
    import skvt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire skvt_sts_t sts,
    output skvt_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_DELETE   = 3'd3;
    localparam logic [2:0] S_MISS     = 3'd4;
    localparam logic [2:0] S_PUT      = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_take = 1'b1;
                if (sts.in_fire)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.mode)
                    MODE_BYTE:
                    begin
                        cmd.byte_store = 1'b1;
                        state_next     = S_IDLE;
                    end
                    MODE_INSERT:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = S_IDLE;
                            if (sts.too_long)
                            begin
                                cmd.emit_status = ST_TOO_LONG;
                                cmd.ins_abort   = 1'b1;
                            end
                            else if (sts.full)
                            begin
                                cmd.emit_status = ST_FULL;
                                cmd.ins_abort   = 1'b1;
                            end
                            else
                            begin
                                cmd.emit_status = ST_STORED;
                                cmd.ins_commit  = 1'b1;
                            end
                        end
                    end
                    MODE_DELETE, MODE_LOOKUP:
                    begin
                        if (sts.key_empty)
                        begin
                            state_next = S_MISS;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.rd_hit)
                begin
                    cmd.hit_latch = 1'b1;
                    if (sts.mode == MODE_LOOKUP)
                    begin
                        cmd.len_rd = 1'b1;
                        state_next = S_PUT;
                    end
                    else
                    begin
                        state_next = S_DELETE;
                    end
                end
                else
                begin
                    cmd.scan_issue = sts.scan_more;
                    if (!sts.scan_more && !sts.rd_vld)
                    begin
                        state_next = S_MISS;
                    end
                end
            end
            S_DELETE:
            begin
                if (sts.out_free)
                begin
                    cmd.del_write   = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_DELETED;
                    state_next      = S_IDLE;
                end
            end
            S_MISS:
            begin
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
            end
            S_PUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_FOUND;
                    if (sts.put_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.put_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/skvt_dpath.sv @@
// ---------------------------------------------------------------------------
// skvt_dpath
// Configuration, slot memories, append and search counters, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module skvt_dpath
    import skvt_pkg::*;
#(
    parameter int MAX_SLOTS       = 64,
    parameter int MAX_VALUE_BYTES = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    skvt_chan_if.sink                 request,
    skvt_chan_if.source               result,
    input  wire skvt_cmd_t            cmd,
    output skvt_sts_t                 sts
);

    localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
    localparam int POS_W      = (MAX_VALUE_BYTES > 1) ? $clog2(MAX_VALUE_BYTES) : 1;
    localparam int CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int BADDR_W    = SLOT_W + POS_W;
    localparam int BYTE_DEPTH = MAX_SLOTS * (2 ** POS_W);

    // Configuration.
    logic [CFG_W-1:0] slot_count_reg;
    logic [CFG_W-1:0] value_cap_reg;

    // Accepted word.
    skvt_req_t req_reg;

    // Append and value-byte bookkeeping.
    logic [CNT_W-1:0]  append_reg;
    logic [SLOT_W-1:0] cur_slot_reg;
    logic [LEN_W-1:0]  pending_reg;
    logic [POS_W-1:0]  pos_reg;

    // Search.
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [CNT_W-1:0]  scan_lim_reg;
    logic              rd_vld_reg;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic [KEY_W-1:0]  key_rd_reg;
    logic [SLOT_W-1:0] found_slot_reg;

    // Lookup run.
    logic [LEN_W-1:0]  len_rd_reg;
    logic [BYTE_W-1:0] byte_rd_reg;
    logic [POS_W-1:0]  put_idx_reg;

    // Result register.
    logic      rsp_valid_reg;
    skvt_rsp_t rsp_reg;

    // Memories.
    logic [KEY_W-1:0]  key_mem  [MAX_SLOTS];
    logic [LEN_W-1:0]  len_mem  [MAX_SLOTS];
    logic [BYTE_W-1:0] byte_mem [BYTE_DEPTH];

    logic [CMP_W-1:0]   active_slots;
    logic [CNT_W-1:0]   scan_lim_next;
    logic               pending_nz;
    logic               key_wr_en;
    logic [SLOT_W-1:0]  key_wr_addr;
    logic [KEY_W-1:0]   key_wr_data;
    logic               byte_rd_en;
    logic [BADDR_W-1:0] byte_rd_addr;
    logic               put_last;

    assign active_slots = (CMP_W'(slot_count_reg) > CMP_W'(MAX_SLOTS))
                        ? CMP_W'(MAX_SLOTS) : CMP_W'(slot_count_reg);
    assign scan_lim_next = (CMP_W'(append_reg) < active_slots)
                         ? append_reg : CNT_W'(active_slots);
    assign pending_nz = (pending_reg != '0);
    assign put_last = (len_rd_reg == '0)
                   || ((LEN_W+1)'(put_idx_reg) + (LEN_W+1)'(1) == (LEN_W+1)'(len_rd_reg));

    assign request.ready = cmd.in_take;
    assign result.valid  = rsp_valid_reg;
    assign result.payload = rsp_reg;

    always_comb
    begin
        sts           = '0;
        sts.in_fire   = request.valid && cmd.in_take;
        sts.mode      = req_reg.mode;
        sts.out_free  = !rsp_valid_reg || result.ready;
        sts.too_long  = ({1'b0, req_reg.val_len} >= value_cap_reg)
                     || ({1'b0, req_reg.val_len} >= CFG_W'(MAX_VALUE_BYTES));
        sts.full      = CMP_W'(append_reg) >= active_slots;
        sts.key_empty = (req_reg.key == EMPTY_KEY);
        sts.scan_more = scan_idx_reg < scan_lim_reg;
        sts.rd_vld    = rd_vld_reg;
        sts.rd_hit    = rd_vld_reg && (key_rd_reg == req_reg.key);
        sts.put_last  = put_last;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SLOT_COUNT_RST;
            value_cap_reg  <= VALUE_CAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SLOT_COUNT: slot_count_reg <= cfg_data;
                REG_VALUE_CAP:  value_cap_reg  <= cfg_data;
                default:        slot_count_reg <= slot_count_reg;
            endcase
        end
    end

    // Control counters and valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            append_reg    <= '0;
            pending_reg   <= '0;
            pos_reg       <= '0;
            scan_idx_reg  <= '0;
            scan_lim_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            put_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ins_commit)
            begin
                append_reg  <= append_reg + CNT_W'(1);
                pending_reg <= req_reg.val_len;
                pos_reg     <= '0;
            end
            else if (cmd.ins_abort)
            begin
                pending_reg <= '0;
                pos_reg     <= '0;
            end
            else if (cmd.byte_store && pending_nz)
            begin
                pending_reg <= pending_reg - LEN_W'(1);
                pos_reg     <= pos_reg + POS_W'(1);
            end

            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
                scan_lim_reg <= scan_lim_next;
            end
            else if (cmd.scan_issue)
            begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
            rd_vld_reg <= cmd.scan_issue;

            if (cmd.len_rd)
            begin
                put_idx_reg <= '0;
            end
            else if (cmd.put_next)
            begin
                put_idx_reg <= put_idx_reg + POS_W'(1);
            end

            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (sts.in_fire)
        begin
            req_reg <= request.payload;
        end
        if (cmd.ins_commit)
        begin
            cur_slot_reg <= append_reg[SLOT_W-1:0];
        end
        if (cmd.hit_latch)
        begin
            found_slot_reg <= rd_idx_reg;
        end
        if (cmd.emit)
        begin
            rsp_reg.status <= cmd.emit_status;
            if (cmd.emit_status == ST_FOUND)
            begin
                rsp_reg.found_key  <= req_reg.key;
                rsp_reg.found_len  <= len_rd_reg;
                rsp_reg.found_byte <= (len_rd_reg == '0) ? '0 : byte_rd_reg;
                rsp_reg.last       <= put_last;
            end
            else
            begin
                rsp_reg.found_key  <= '0;
                rsp_reg.found_len  <= '0;
                rsp_reg.found_byte <= '0;
                rsp_reg.last       <= 1'b1;
            end
        end
    end

    // Key memory: one write port, one registered read port for the search.
    assign key_wr_en   = cmd.ins_commit || cmd.del_write;
    assign key_wr_addr = cmd.del_write ? found_slot_reg : append_reg[SLOT_W-1:0];
    assign key_wr_data = cmd.del_write ? EMPTY_KEY : req_reg.key;

    always_ff @(posedge clk)
    begin
        if (key_wr_en)
        begin
            key_mem[key_wr_addr] <= key_wr_data;
        end
        if (cmd.scan_issue)
        begin
            key_rd_reg <= key_mem[scan_idx_reg[SLOT_W-1:0]];
            rd_idx_reg <= scan_idx_reg[SLOT_W-1:0];
        end
    end

    // Length memory.
    always_ff @(posedge clk)
    begin
        if (cmd.ins_commit)
        begin
            len_mem[append_reg[SLOT_W-1:0]] <= req_reg.val_len;
        end
        if (cmd.len_rd)
        begin
            len_rd_reg <= len_mem[rd_idx_reg];
        end
    end

    // Value byte memory, addressed by slot and byte position.
    assign byte_rd_en   = cmd.len_rd || cmd.put_next;
    assign byte_rd_addr = cmd.len_rd ? {rd_idx_reg, POS_W'(0)}
                                     : {found_slot_reg, put_idx_reg + POS_W'(1)};

    always_ff @(posedge clk)
    begin
        if (cmd.byte_store && pending_nz)
        begin
            byte_mem[{cur_slot_reg, pos_reg}] <= req_reg.value_byte;
        end
        if (byte_rd_en)
        begin
            byte_rd_reg <= byte_mem[byte_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/slot_key_value_table_core.sv @@
// ---------------------------------------------------------------------------
// slot_key_value_table_core
// Append-only slot table of keys and short values with search by key.
// ---------------------------------------------------------------------------
// The block takes one request word at a time. An insert header or a value
// byte is acted on in the cycle after it is accepted, before the next word
// can be taken; an insert header also waits there while the output register
// is still held by the consumer. A delete or a lookup searches the written
// slots in order through the single read port of the key memory, one slot
// per cycle, up to the first match and at most the lesser of the slot count
// and the number of slots ever inserted. A lookup that hits then streams its
// value bytes, one result word per cycle while the result side keeps ready
// high. A new request is taken only after the previous one has handed its
// last result to the output register, which may still be waiting for the
// consumer. Slots are claimed in append order and never reused; a deleted
// slot holds the all-ones key, which never matches. Slots beyond the append
// count are never read, so the memories need no clearing pass after reset.
`default_nettype none

module slot_key_value_table_core
    import skvt_pkg::*;
#(
    parameter int MAX_SLOTS       = 64,
    parameter int MAX_VALUE_BYTES = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    skvt_chan_if.sink                 request,
    skvt_chan_if.source               result
);

    // Commands flow from the controller into the datapath; status flows back.
    skvt_cmd_t cmd;
    skvt_sts_t sts;

    // The controller sequences dispatch, the pipelined key search, the delete
    // write and the lookup byte run.
    skvt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // The datapath holds the configuration registers, the key, length and
    // value byte memories, the append counter and the result register.
    skvt_dpath #(
        .MAX_SLOTS       (MAX_SLOTS),
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request),
        .result    (result),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

@@ src/skvt_checker.sv @@
// ---------------------------------------------------------------------------
// skvt_checker
// Port-level checks of the slot key-value table, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "slot_key_value_table_core_macros.svh"

module skvt_checker
    import skvt_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic [STAT_W-1:0] rsp_status,
    input wire logic [KEY_W-1:0]  rsp_key,
    input wire logic [LEN_W-1:0]  rsp_len,
    input wire logic [BYTE_W-1:0] rsp_byte,
    input wire logic              rsp_last
);

    // A stalled result word stays and holds its contents.
    `SKVT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_status) && $stable(rsp_key) && $stable(rsp_len)
        && $stable(rsp_byte) && $stable(rsp_last), "result word changed while stalled")

    // Requests are processed one at a time.
    `SKVT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready,
        "request taken in back-to-back cycles")

    // Only a lookup hit carries data or spans more than one word.
    `SKVT_ASSERT_IMPL(a_plain_status, rsp_valid && (rsp_status != ST_FOUND),
        rsp_last && (rsp_key == '0) && (rsp_len == '0) && (rsp_byte == '0),
        "non-lookup result carries data")

    // Status codes stay within the defined set.
    `SKVT_ASSERT_IMPL(a_status_range, rsp_valid, rsp_status <= ST_FOUND,
        "undefined status code")

endmodule

bind slot_key_value_table_core skvt_checker u_skvt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (request.valid),
    .req_ready  (request.ready),
    .rsp_valid  (result.valid),
    .rsp_ready  (result.ready),
    .rsp_status (result.payload.status),
    .rsp_key    (result.payload.found_key),
    .rsp_len    (result.payload.found_len),
    .rsp_byte   (result.payload.found_byte),
    .rsp_last   (result.payload.last)
);

`default_nettype wire
